FILE: rtl/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg
// Shared types and defaults for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

  localparam int unsigned CoordWidthDef = 16;

  typedef struct packed {
    logic valid;
    logic hit;
  } ctl_t;

endpackage

FILE: rtl/segi_setup.sv
// ----------------------------------------------------------------------------
// segi_setup
// Differences, cross products, sign normalization and hit test (3 stages).
// ----------------------------------------------------------------------------
module segi_setup #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [W-1:0]   ax1_i,
  input  logic signed [W-1:0]   ay1_i,
  input  logic signed [W-1:0]   ax2_i,
  input  logic signed [W-1:0]   ay2_i,
  input  logic signed [W-1:0]   bx1_i,
  input  logic signed [W-1:0]   by1_i,
  input  logic signed [W-1:0]   bx2_i,
  input  logic signed [W-1:0]   by2_i,
  output segi_pkg::ctl_t        ctl_o,
  output logic [2*W:0]          den_o,
  output logic [2*W:0]          tn_o,
  output logic [W-1:0]          mx_o,
  output logic [W-1:0]          my_o,
  output logic                  sx_o,
  output logic                  sy_o,
  output logic signed [W-1:0]   a1x_o,
  output logic signed [W-1:0]   a1y_o
);
  import segi_pkg::*;

  localparam int unsigned D = 2 * W + 2;
  localparam int unsigned U = 2 * W + 1;

  // stage 0: differences
  logic              v0_q;
  logic signed [W:0] dax_q, day_q, dbx_q, dby_q, ox_q, oy_q;
  logic signed [W-1:0] a1x0_q, a1y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax_q  <= (W+1)'(ax2_i) - (W+1)'(ax1_i);
      day_q  <= (W+1)'(ay2_i) - (W+1)'(ay1_i);
      dbx_q  <= (W+1)'(bx2_i) - (W+1)'(bx1_i);
      dby_q  <= (W+1)'(by2_i) - (W+1)'(by1_i);
      ox_q   <= (W+1)'(ax1_i) - (W+1)'(bx1_i);
      oy_q   <= (W+1)'(ay1_i) - (W+1)'(by1_i);
      a1x0_q <= ax1_i;
      a1y0_q <= ay1_i;
    end
  end

  // stage 1: six products
  logic              v1_q;
  logic signed [D-1:0] p_dd1_q, p_dd2_q, p_t1_q, p_t2_q, p_s1_q, p_s2_q;
  logic signed [D-1:0] p_dd1_d, p_dd2_d, p_t1_d, p_t2_d, p_s1_d, p_s2_d;
  logic [W:0]        dax_abs, day_abs;
  logic [W-1:0]      mx1_q, my1_q;
  logic              sx1_q, sy1_q;
  logic signed [W-1:0] a1x1_q, a1y1_q;

  assign p_dd1_d = D'(dby_q) * D'(dax_q);
  assign p_dd2_d = D'(dbx_q) * D'(day_q);
  assign p_t1_d  = D'(dbx_q) * D'(oy_q);
  assign p_t2_d  = D'(dby_q) * D'(ox_q);
  assign p_s1_d  = D'(dax_q) * D'(oy_q);
  assign p_s2_d  = D'(day_q) * D'(ox_q);
  assign dax_abs = dax_q[W] ? (W+1)'(-dax_q) : (W+1)'(dax_q);
  assign day_abs = day_q[W] ? (W+1)'(-day_q) : (W+1)'(day_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_dd1_q <= p_dd1_d;
      p_dd2_q <= p_dd2_d;
      p_t1_q  <= p_t1_d;
      p_t2_q  <= p_t2_d;
      p_s1_q  <= p_s1_d;
      p_s2_q  <= p_s2_d;
      mx1_q   <= dax_abs[W-1:0];
      my1_q   <= day_abs[W-1:0];
      sx1_q   <= dax_q[W];
      sy1_q   <= day_q[W];
      a1x1_q  <= a1x0_q;
      a1y1_q  <= a1y0_q;
    end
  end

  // stage 2: normalize to positive denominator and test range
  logic signed [D-1:0] den_s, tn_s, sn_s, den_n, tn_n, sn_n;
  logic                hit_d;
  ctl_t                ctl_q;

  assign den_s = p_dd1_q - p_dd2_q;
  assign tn_s  = p_t1_q - p_t2_q;
  assign sn_s  = p_s1_q - p_s2_q;
  assign den_n = den_s[D-1] ? -den_s : den_s;
  assign tn_n  = den_s[D-1] ? -tn_s  : tn_s;
  assign sn_n  = den_s[D-1] ? -sn_s  : sn_s;

  always_comb begin
    hit_d = (den_s != '0) && !tn_n[D-1] && !sn_n[D-1] &&
            (tn_n <= den_n) && (sn_n <= den_n) &&
            !((tn_n == '0) && (sn_n == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= v1_q;
      ctl_q.hit   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_n[U-1:0];
      tn_o  <= tn_n[U-1:0];
      mx_o  <= mx1_q;
      my_o  <= my1_q;
      sx_o  <= sx1_q;
      sy_o  <= sy1_q;
      a1x_o <= a1x1_q;
      a1y_o <= a1y1_q;
    end
  end

  assign ctl_o = ctl_q;

endmodule

FILE: rtl/segi_cell.sv
// ----------------------------------------------------------------------------
// segi_cell
// One quotient digit per axis of floor(tn * |dA| / den), multiplier bits MSB first.
// ----------------------------------------------------------------------------
module segi_cell #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  segi_pkg::ctl_t        ctl_i,
  input  logic [2*W:0]          den_i,
  input  logic [2*W:0]          tn_i,
  input  logic [2*W:0]          rx_i,
  input  logic [2*W:0]          ry_i,
  input  logic [W-1:0]          qx_i,
  input  logic [W-1:0]          qy_i,
  input  logic [W-1:0]          mx_i,
  input  logic [W-1:0]          my_i,
  input  logic                  sx_i,
  input  logic                  sy_i,
  input  logic signed [W-1:0]   a1x_i,
  input  logic signed [W-1:0]   a1y_i,
  output segi_pkg::ctl_t        ctl_o,
  output logic [2*W:0]          den_o,
  output logic [2*W:0]          tn_o,
  output logic [2*W:0]          rx_o,
  output logic [2*W:0]          ry_o,
  output logic [W-1:0]          qx_o,
  output logic [W-1:0]          qy_o,
  output logic [W-1:0]          mx_o,
  output logic [W-1:0]          my_o,
  output logic                  sx_o,
  output logic                  sy_o,
  output logic signed [W-1:0]   a1x_o,
  output logic signed [W-1:0]   a1y_o
);
  import segi_pkg::*;

  localparam int unsigned U = 2 * W + 1;

  logic [U+1:0] den1, den2, rx2, ry2, rx3, ry3;
  logic [1:0]   dx, dy;
  ctl_t         ctl_q;

  assign den1 = {2'b00, den_i};
  assign den2 = {1'b0, den_i, 1'b0};

  always_comb begin
    rx2 = {1'b0, rx_i, 1'b0} + (mx_i[W-1] ? {2'b00, tn_i} : '0);
    ry2 = {1'b0, ry_i, 1'b0} + (my_i[W-1] ? {2'b00, tn_i} : '0);
    if (rx2 >= den2) begin
      rx3 = rx2 - den2;
      dx  = 2'd2;
    end else if (rx2 >= den1) begin
      rx3 = rx2 - den1;
      dx  = 2'd1;
    end else begin
      rx3 = rx2;
      dx  = 2'd0;
    end
    if (ry2 >= den2) begin
      ry3 = ry2 - den2;
      dy  = 2'd2;
    end else if (ry2 >= den1) begin
      ry3 = ry2 - den1;
      dy  = 2'd1;
    end else begin
      ry3 = ry2;
      dy  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      tn_o  <= tn_i;
      rx_o  <= rx3[U-1:0];
      ry_o  <= ry3[U-1:0];
      qx_o  <= W'({qx_i, 1'b0} + (W+1)'(dx));
      qy_o  <= W'({qy_i, 1'b0} + (W+1)'(dy));
      mx_o  <= {mx_i[W-2:0], 1'b0};
      my_o  <= {my_i[W-2:0], 1'b0};
      sx_o  <= sx_i;
      sy_o  <= sy_i;
      a1x_o <= a1x_i;
      a1y_o <= a1y_i;
    end
  end

  assign ctl_o = ctl_q;

endmodule

FILE: rtl/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// 2D segment intersection test with exact fixed-point intersection point.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                          tuser
// s_axis   in   ax1 ay1 ax2 ay2 bx1 by1 bx2 by2            -
// m_axis   out  ix iy                                       hit
//
// One transaction accepted per cycle unless the output stalls; each passes three
// setup stages, divider cells (one quotient digit each) and the output register.
// Reset clears all valid flags; payload registers are not reset.
// A stalled output freezes the whole pipeline; empty stages do not block input.
// ----------------------------------------------------------------------------
module segment_intersection #(
  parameter int unsigned COORD_WIDTH = segi_pkg::CoordWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [8*COORD_WIDTH-1:0] s_axis_tdata,  // ax1 ay1 ax2 ay2 bx1 by1 bx2 by2
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [2*COORD_WIDTH-1:0] m_axis_tdata,  // ix iy
  output logic                     m_axis_tuser   // hit
);
  import segi_pkg::*;

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned U = 2 * W + 1;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  ctl_t                ctl   [W+1];
  logic [U-1:0]        den   [W+1];
  logic [U-1:0]        tn    [W+1];
  logic [U-1:0]        rx    [W+1];
  logic [U-1:0]        ry    [W+1];
  logic [W-1:0]        qx    [W+1];
  logic [W-1:0]        qy    [W+1];
  logic [W-1:0]        mx    [W+1];
  logic [W-1:0]        my    [W+1];
  logic                sx    [W+1];
  logic                sy    [W+1];
  logic signed [W-1:0] a1x   [W+1];
  logic signed [W-1:0] a1y   [W+1];

  segi_setup #(.W(W)) u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .ax1_i   (s_axis_tdata[0*W +: W]),
    .ay1_i   (s_axis_tdata[1*W +: W]),
    .ax2_i   (s_axis_tdata[2*W +: W]),
    .ay2_i   (s_axis_tdata[3*W +: W]),
    .bx1_i   (s_axis_tdata[4*W +: W]),
    .by1_i   (s_axis_tdata[5*W +: W]),
    .bx2_i   (s_axis_tdata[6*W +: W]),
    .by2_i   (s_axis_tdata[7*W +: W]),
    .ctl_o   (ctl[0]),
    .den_o   (den[0]),
    .tn_o    (tn[0]),
    .mx_o    (mx[0]),
    .my_o    (my[0]),
    .sx_o    (sx[0]),
    .sy_o    (sy[0]),
    .a1x_o   (a1x[0]),
    .a1y_o   (a1y[0])
  );

  assign rx[0] = '0;
  assign ry[0] = '0;
  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_cell
    segi_cell #(.W(W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl[k]),
      .den_i  (den[k]),
      .tn_i   (tn[k]),
      .rx_i   (rx[k]),
      .ry_i   (ry[k]),
      .qx_i   (qx[k]),
      .qy_i   (qy[k]),
      .mx_i   (mx[k]),
      .my_i   (my[k]),
      .sx_i   (sx[k]),
      .sy_i   (sy[k]),
      .a1x_i  (a1x[k]),
      .a1y_i  (a1y[k]),
      .ctl_o  (ctl[k+1]),
      .den_o  (den[k+1]),
      .tn_o   (tn[k+1]),
      .rx_o   (rx[k+1]),
      .ry_o   (ry[k+1]),
      .qx_o   (qx[k+1]),
      .qy_o   (qy[k+1]),
      .mx_o   (mx[k+1]),
      .my_o   (my[k+1]),
      .sx_o   (sx[k+1]),
      .sy_o   (sy[k+1]),
      .a1x_o  (a1x[k+1]),
      .a1y_o  (a1y[k+1])
    );
  end

  // output register
  logic         out_valid_q, out_hit_q;
  logic [W-1:0] ix_q, iy_q, ix_d, iy_d;

  assign ix_d = !ctl[W].hit ? '0 :
                sx[W] ? W'(a1x[W] - $signed(qx[W])) : W'(a1x[W] + $signed(qx[W]));
  assign iy_d = !ctl[W].hit ? '0 :
                sy[W] ? W'(a1y[W] - $signed(qy[W])) : W'(a1y[W] + $signed(qy[W]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl[W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= ctl[W].hit;
      ix_q      <= ix_d;
      iy_q      <= iy_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {iy_q, ix_q};

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result carries nonzero point");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctl[W]) && $stable(qx[W]) && $stable(qy[W]))
    else $error("cell chain moved during stall");
`endif

endmodule
